// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the pressure/temperature compensator
// Holds the channel words, the decoded coefficient set, the words passed
// between pipeline sections and the rounding helper.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_LOW  = 2'd0;
  localparam logic [1:0] CFG_IDX_MID  = 2'd1;
  localparam logic [1:0] CFG_IDX_HIGH = 2'd2;

  // Plausibility window: temperature in Q30 degC, pressure in Q16 Pa
  localparam logic signed [41:0] TC_LO  = -42'sd42949672960;
  localparam logic signed [41:0] TC_HI  = 42'sd91268055040;
  localparam logic signed [47:0] ACC_LO = 48'sd1966080000;
  localparam logic signed [47:0] ACC_HI = 48'sd8192000000;

  // Output saturation limits
  localparam logic signed [17:0] TCENT_MAX = 18'sd32767;
  localparam logic signed [17:0] TCENT_MIN = -18'sd32768;
  localparam logic signed [41:0] PCENT_MAX = 42'sd16777215;

  typedef struct packed {
    logic [23:0] press_adc;
    logic [23:0] temp_adc;
  } in_data_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [23:0]        pressure_centi_pa;
    logic               in_range;
  } out_data_t;

  // Decoded calibration coefficients (P1 and P2 already offset by 16384)
  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  // Temperature section -> polynomial section
  typedef struct packed {
    logic signed [41:0] tc;
    logic signed [25:0] tq;
    logic [23:0]        rawp;
    logic [30:0]        r;
    logic [54:0]        rraw;
  } tmid_t;

  // Polynomial section -> summing section
  typedef struct packed {
    logic [23:0]        rawp;
    logic signed [42:0] p6tq;
    logic signed [42:0] p2tq;
    logic signed [43:0] p7tsq;
    logic signed [43:0] p3tsq;
    logic signed [53:0] p8tcu;
    logic signed [53:0] p4tcu;
    logic signed [63:0] ru;
    logic signed [63:0] rrp11;
    logic signed [17:0] tcent;
    logic               tok;
  } pmid_t;

  // Summing section -> output section
  typedef struct packed {
    logic signed [47:0] acc;
    logic signed [17:0] tcent;
    logic               tok;
  } smid_t;

  // Shift right with round to nearest, ties away from zero (sh >= 1)
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                 input logic [5:0] sh);
    logic [63:0] m;
    logic [63:0] half;
    half = 64'd1 << (sh - 6'd1);
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + half) >> sh;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/bpc_temp.sv =====
// ----------------------------------------------------------------------------
// bpc_temp: temperature linearization section
// Four stages: offset, products, quadratic sum, rounding to Q30 and Q14.
// Also forms the raw pressure square terms used later.
// ----------------------------------------------------------------------------
module bpc_temp
  import bpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  coef_t    coef,
  input  logic     up_vld,
  input  in_data_t up_data,
  output logic     up_rdy,
  output logic     dn_vld,
  output tmid_t    dn_data,
  input  logic     dn_rdy
);

  localparam int NS = 4;

  typedef struct packed {
    logic signed [24:0] d;
    logic [23:0]        rawp;
    logic signed [41:0] dt2;
    logic [47:0]        dd;
    logic [47:0]        rr;
    logic signed [59:0] tn;
    logic [30:0]        r;
    logic signed [41:0] tc;
    logic signed [25:0] tq;
    logic [54:0]        rraw;
  } tst_t;

  logic [NS-1:0] v_r, v_nxt, en;
  tst_t s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_vld : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: offset against T1
  always_comb begin
    s0_nxt = '0;
    s0_nxt.d = $signed({1'b0, up_data.temp_adc}) - $signed({1'b0, coef.t1, 8'b0});
    s0_nxt.rawp = up_data.press_adc;
  end

  // Stage 1: linear and square products
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.dt2 = 42'(s0_r.d) * 42'($signed({1'b0, coef.t2}));
    s1_nxt.dd = 48'(50'(s0_r.d) * 50'(s0_r.d));
    s1_nxt.rr = 48'(s0_r.rawp) * 48'(s0_r.rawp);
  end

  // Stage 2: quadratic sum in Q48, scale raw square
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.tn = $signed({s1_r.dt2, 18'b0})
              + 60'(57'($signed({1'b0, s1_r.dd})) * 57'(coef.t3));
    s2_nxt.r = 31'((49'(s1_r.rr) + 49'd65536) >> 17);
  end

  // Stage 3: round temperature, cube-term product of raw pressure
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.tc = 42'(rnd_shr(64'(s2_r.tn), 6'd18));
    s3_nxt.tq = 26'(rnd_shr(64'(s2_r.tn), 6'd34));
    s3_nxt.rraw = 55'(s2_r.r) * 55'(s2_r.rawp);
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_r <= s0_nxt;
    if (en[1]) s1_r <= s1_nxt;
    if (en[2]) s2_r <= s2_nxt;
    if (en[3]) s3_r <= s3_nxt;
  end

  assign up_rdy = en[0];
  assign dn_vld = v_r[NS-1];

  always_comb begin
    dn_data.tc   = s3_r.tc;
    dn_data.tq   = s3_r.tq;
    dn_data.rawp = s3_r.rawp;
    dn_data.r    = s3_r.r;
    dn_data.rraw = s3_r.rraw;
  end

endmodule

// ===== rtl/bpc_poly.sv =====
// ----------------------------------------------------------------------------
// bpc_poly: temperature powers and coefficient products
// Five stages: first products, square, square products, cube, cube products.
// ----------------------------------------------------------------------------
module bpc_poly
  import bpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  coef_t coef,
  input  logic  up_vld,
  input  tmid_t up_data,
  output logic  up_rdy,
  output logic  dn_vld,
  output pmid_t dn_data,
  input  logic  dn_rdy
);

  localparam int NS = 5;

  typedef struct packed {
    logic signed [25:0] tq;
    logic [23:0]        rawp;
    logic [30:0]        r;
    logic signed [49:0] tqq;
    logic signed [42:0] p6tq;
    logic signed [42:0] p2tq;
    logic signed [32:0] u;
    logic signed [63:0] rrp11;
    logic signed [49:0] tc100;
    logic               tok;
    logic signed [35:0] tsq;
    logic signed [63:0] ru;
    logic signed [17:0] tcent;
    logic signed [61:0] tsqtq;
    logic signed [43:0] p7tsq;
    logic signed [43:0] p3tsq;
    logic signed [45:0] tcu;
    logic signed [53:0] p8tcu;
    logic signed [53:0] p4tcu;
  } pst_t;

  logic [NS-1:0] v_r, v_nxt, en;
  pst_t s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_vld : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: products with the Q14 temperature, range check on temperature
  always_comb begin
    s0_nxt = '0;
    s0_nxt.tq    = up_data.tq;
    s0_nxt.rawp  = up_data.rawp;
    s0_nxt.r     = up_data.r;
    s0_nxt.tqq   = 50'(52'(up_data.tq) * 52'(up_data.tq));
    s0_nxt.p6tq  = 43'($signed({1'b0, coef.p6})) * 43'(up_data.tq);
    s0_nxt.p2tq  = 43'(coef.p2) * 43'(up_data.tq);
    s0_nxt.u     = 33'($signed({coef.p9, 14'b0})) + 33'(coef.p10) * 33'(up_data.tq);
    s0_nxt.rrp11 = 64'($signed({1'b0, up_data.rraw})) * 64'(coef.p11);
    s0_nxt.tc100 = 50'(up_data.tc) * 50'sd100;
    s0_nxt.tok   = (up_data.tc >= TC_LO) && (up_data.tc <= TC_HI);
  end

  // Stage 1: round square, raw-square times U, centi-degree temperature
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.tsq   = 36'(rnd_shr(64'(s0_r.tqq), 6'd14));
    s1_nxt.ru    = 64'($signed({1'b0, s0_r.r})) * 64'(s0_r.u);
    s1_nxt.tcent = 18'(rnd_shr(64'(s0_r.tc100), 6'd30));
  end

  // Stage 2: cube product and square-term products
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.tsqtq = 62'(s1_r.tsq) * 62'(s1_r.tq);
    s2_nxt.p7tsq = 44'(coef.p7) * 44'(s1_r.tsq);
    s2_nxt.p3tsq = 44'(coef.p3) * 44'(s1_r.tsq);
  end

  // Stage 3: round cube
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.tcu = 46'(rnd_shr(64'(s2_r.tsqtq), 6'd14));
  end

  // Stage 4: cube-term products
  always_comb begin
    s4_nxt = s3_r;
    s4_nxt.p8tcu = 54'(coef.p8) * 54'(s3_r.tcu);
    s4_nxt.p4tcu = 54'(coef.p4) * 54'(s3_r.tcu);
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_r <= s0_nxt;
    if (en[1]) s1_r <= s1_nxt;
    if (en[2]) s2_r <= s2_nxt;
    if (en[3]) s3_r <= s3_nxt;
    if (en[4]) s4_r <= s4_nxt;
  end

  assign up_rdy = en[0];
  assign dn_vld = v_r[NS-1];

  always_comb begin
    dn_data.rawp  = s4_r.rawp;
    dn_data.p6tq  = s4_r.p6tq;
    dn_data.p2tq  = s4_r.p2tq;
    dn_data.p7tsq = s4_r.p7tsq;
    dn_data.p3tsq = s4_r.p3tsq;
    dn_data.p8tcu = s4_r.p8tcu;
    dn_data.p4tcu = s4_r.p4tcu;
    dn_data.ru    = s4_r.ru;
    dn_data.rrp11 = s4_r.rrp11;
    dn_data.tcent = s4_r.tcent;
    dn_data.tok   = s4_r.tok;
  end

endmodule

// ===== rtl/bpc_sum.sv =====
// ----------------------------------------------------------------------------
// bpc_sum: pressure accumulation
// Five stages: round terms, sum offset and sensitivity, raw times
// sensitivity, round, final accumulate in Q16 Pa.
// ----------------------------------------------------------------------------
module bpc_sum
  import bpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  coef_t coef,
  input  logic  up_vld,
  input  pmid_t up_data,
  output logic  up_rdy,
  output logic  dn_vld,
  output smid_t dn_data,
  input  logic  dn_rdy
);

  localparam int NS = 5;

  typedef struct packed {
    logic [23:0]        rawp;
    logic signed [17:0] tcent;
    logic               tok;
    logic signed [38:0] a6;
    logic signed [37:0] a7;
    logic signed [40:0] a8;
    logic signed [35:0] b2;
    logic signed [33:0] b3;
    logic signed [38:0] b4;
    logic signed [34:0] aru;
    logic signed [31:0] a11;
    logic signed [40:0] s;
    logic signed [47:0] accp;
    logic signed [63:0] rs;
    logic signed [43:0] ars;
    logic signed [47:0] acc;
  } sst_t;

  logic [NS-1:0] v_r, v_nxt, en;
  sst_t s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || dn_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_vld : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: round every product term
  always_comb begin
    s0_nxt = '0;
    s0_nxt.rawp  = up_data.rawp;
    s0_nxt.tcent = up_data.tcent;
    s0_nxt.tok   = up_data.tok;
    s0_nxt.a6    = 39'(rnd_shr(64'(up_data.p6tq), 6'd4));
    s0_nxt.a7    = 38'(rnd_shr(64'(up_data.p7tsq), 6'd6));
    s0_nxt.a8    = 41'(rnd_shr(64'(up_data.p8tcu), 6'd13));
    s0_nxt.b2    = 36'(rnd_shr(64'(up_data.p2tq), 6'd7));
    s0_nxt.b3    = 34'(rnd_shr(64'(up_data.p3tsq), 6'd10));
    s0_nxt.b4    = 39'(rnd_shr(64'(up_data.p4tcu), 6'd15));
    s0_nxt.aru   = 35'(rnd_shr(up_data.ru, 6'd29));
    s0_nxt.a11   = 32'(rnd_shr(up_data.rrp11, 6'd32));
  end

  // Stage 1: sensitivity and partial offset sums
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.s = 41'($signed({coef.p1, 16'b0})) + 41'(s0_r.b2) + 41'(s0_r.b3)
             + 41'(s0_r.b4);
    s1_nxt.accp = 48'($signed({1'b0, coef.p5, 19'b0})) + 48'(s0_r.a6)
                + 48'(s0_r.a7) + 48'(s0_r.a8) + 48'(s0_r.aru) + 48'(s0_r.a11);
  end

  // Stage 2: raw pressure times sensitivity
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.rs = 64'($signed({1'b0, s1_r.rawp})) * 64'(s1_r.s);
  end

  // Stage 3: round sensitivity term
  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.ars = 44'(rnd_shr(s2_r.rs, 6'd20));
  end

  // Stage 4: final accumulate
  always_comb begin
    s4_nxt = s3_r;
    s4_nxt.acc = s3_r.accp + 48'(s3_r.ars);
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_r <= s0_nxt;
    if (en[1]) s1_r <= s1_nxt;
    if (en[2]) s2_r <= s2_nxt;
    if (en[3]) s3_r <= s3_nxt;
    if (en[4]) s4_r <= s4_nxt;
  end

  assign up_rdy = en[0];
  assign dn_vld = v_r[NS-1];

  always_comb begin
    dn_data.acc   = s4_r.acc;
    dn_data.tcent = s4_r.tcent;
    dn_data.tok   = s4_r.tok;
  end

endmodule

// ===== rtl/bpc_out.sv =====
// ----------------------------------------------------------------------------
// bpc_out: output scaling, saturation and result register
// Three stages: scale to centi-pascal, round, saturate into the result word.
// ----------------------------------------------------------------------------
module bpc_out
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_vld,
  input  smid_t     up_data,
  output logic      up_rdy,
  output logic      out_valid,
  output out_data_t out_data,
  input  logic      out_stall
);

  localparam int NS = 3;

  typedef struct packed {
    logic signed [55:0] acc100;
    logic signed [17:0] tcent;
    logic               tok;
    logic               pok;
    logic signed [41:0] pcent;
  } ost_t;

  logic [NS-1:0] v_r, v_nxt, en;
  ost_t      s0_r, s0_nxt, s1_r, s1_nxt;
  out_data_t res_r, res_nxt;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? up_vld : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: scale pressure, check pressure window
  always_comb begin
    s0_nxt = '0;
    s0_nxt.acc100 = 56'(up_data.acc) * 56'sd100;
    s0_nxt.tcent  = up_data.tcent;
    s0_nxt.tok    = up_data.tok;
    s0_nxt.pok    = (up_data.acc >= ACC_LO) && (up_data.acc <= ACC_HI);
  end

  // Stage 1: round pressure
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.pcent = 42'(rnd_shr(64'(s0_r.acc100), 6'd16));
  end

  // Stage 2: saturate into the result word
  always_comb begin
    if (s1_r.tcent > TCENT_MAX) begin
      res_nxt.temperature_centi = 16'(TCENT_MAX);
    end else if (s1_r.tcent < TCENT_MIN) begin
      res_nxt.temperature_centi = 16'(TCENT_MIN);
    end else begin
      res_nxt.temperature_centi = 16'(s1_r.tcent);
    end
    if (s1_r.pcent < 42'sd0) begin
      res_nxt.pressure_centi_pa = '0;
    end else if (s1_r.pcent > PCENT_MAX) begin
      res_nxt.pressure_centi_pa = 24'(PCENT_MAX);
    end else begin
      res_nxt.pressure_centi_pa = 24'(s1_r.pcent);
    end
    res_nxt.in_range = s1_r.tok && s1_r.pok;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_r  <= s0_nxt;
    if (en[1]) s1_r  <= s1_nxt;
    if (en[2]) res_r <= res_nxt;
  end

  assign up_rdy    = en[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = res_r;

endmodule

// ===== rtl/baro_pressure_temp_compensation_top.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top: barometric sensor compensation
// Turns raw 24-bit pressure/temperature samples into compensated values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one raw sample word.
//   Result channel out_valid/out_stall/out_data carries temperature in
//   0.01 degC, pressure in 0.01 Pa and the plausibility flag.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the three
//   calibration words (bytes 0-7, 8-15, 16-20); cfg_ready is always high.
//   Write calibration only while no sample is in flight.
// Timing:
//   17 register stages: the temperature, polynomial, summing and output
//   sections, ending in the result register. One sample per cycle is
//   sustained while out_stall is low (fully pipelined multiply and rounding).
// Reset:
//   Synchronous, active low; clears calibration words to zero and empties
//   the pipeline.
// Stall:
//   out_stall holds the result register; earlier stages keep filling empty
//   slots and in_stall rises only when every stage holds a word.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_data_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]  cal_lo_r, cal_mid_r;
  logic [39:0]  cal_hi_r;
  logic [167:0] cal;
  coef_t        coef;

  logic  t_rdy, p_vld, p_rdy, s_vld, s_rdy, o_vld, o_rdy;
  tmid_t t_data;
  pmid_t p_data;
  smid_t s_data;

  assign cfg_ready = 1'b1;

  // Capture calibration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r  <= '0;
      cal_mid_r <= '0;
      cal_hi_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_LOW:  cal_lo_r  <= cfg_data;
        CFG_IDX_MID:  cal_mid_r <= cfg_data;
        CFG_IDX_HIGH: cal_hi_r  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Decode calibration bytes into coefficients
  assign cal = {cal_hi_r, cal_mid_r, cal_lo_r};

  always_comb begin
    coef.t1  = cal[15:0];
    coef.t2  = cal[31:16];
    coef.t3  = $signed(cal[39:32]);
    coef.p1  = 17'($signed(cal[55:40])) - 17'sd16384;
    coef.p2  = 17'($signed(cal[71:56])) - 17'sd16384;
    coef.p3  = $signed(cal[79:72]);
    coef.p4  = $signed(cal[87:80]);
    coef.p5  = cal[103:88];
    coef.p6  = cal[119:104];
    coef.p7  = $signed(cal[127:120]);
    coef.p8  = $signed(cal[135:128]);
    coef.p9  = $signed(cal[151:136]);
    coef.p10 = $signed(cal[159:152]);
    coef.p11 = $signed(cal[167:160]);
  end

  assign in_stall = !t_rdy;

  bpc_temp u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef),
    .up_vld  (in_valid),
    .up_data (in_data),
    .up_rdy  (t_rdy),
    .dn_vld  (p_vld),
    .dn_data (t_data),
    .dn_rdy  (p_rdy)
  );

  bpc_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef),
    .up_vld  (p_vld),
    .up_data (t_data),
    .up_rdy  (p_rdy),
    .dn_vld  (s_vld),
    .dn_data (p_data),
    .dn_rdy  (s_rdy)
  );

  bpc_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef),
    .up_vld  (s_vld),
    .up_data (p_data),
    .up_rdy  (s_rdy),
    .dn_vld  (o_vld),
    .dn_data (s_data),
    .dn_rdy  (o_rdy)
  );

  bpc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (o_vld),
    .up_data   (s_data),
    .up_rdy    (o_rdy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
